// ===== src/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared codes and field widths of the symbol slot registry.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int FUNC_W = 4;
  localparam int SLOT_W = 5;
  localparam int ERR_W  = 4;
  localparam int PH_W   = 2;
  localparam int GEN_W  = 32;
  localparam int CFG_W  = 6;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN   = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENABLE   = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISABLE  = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN    = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_ACK      = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_FIND     = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 4'd8;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE           = 4'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE          = 4'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY_KEY      = 4'd2;
  localparam logic [ERR_W-1:0] ERR_DUP_ACTIVE     = 4'd3;
  localparam logic [ERR_W-1:0] ERR_NOT_ASSIGNABLE = 4'd4;
  localparam logic [ERR_W-1:0] ERR_CLR_AWAIT      = 4'd5;
  localparam logic [ERR_W-1:0] ERR_EN_UNASSIGNED  = 4'd6;
  localparam logic [ERR_W-1:0] ERR_EN_BEFORE_ACK  = 4'd7;
  localparam logic [ERR_W-1:0] ERR_DIS_UNASSIGNED = 4'd8;
  localparam logic [ERR_W-1:0] ERR_REMAP_ACTIVE   = 4'd9;
  localparam logic [ERR_W-1:0] ERR_NO_CLEAR       = 4'd10;
  localparam logic [ERR_W-1:0] ERR_NOT_READY      = 4'd11;

  // remap phases
  localparam logic [PH_W-1:0] PH_READY  = 2'd0;
  localparam logic [PH_W-1:0] PH_ACTIVE = 2'd1;
  localparam logic [PH_W-1:0] PH_AWAIT  = 2'd2;

endpackage

// ===== src/symbol_slot_registry.sv =====
// ----------------------------------------------------------------------------
// symbol_slot_registry
// Slot table mapping symbol keys to slots, with enable flags, remap phases
// and a wrapping generation counter.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around the key
// store's single read port. A request that touches only its own slot steps
// through dispatch, wait, slot and output before the next one is accepted.
// Assign, enable and complete remap add a duplicate scan, and find symbol
// is a scan; a scan compares one slot per cycle. A finished result waits in
// the output register while the next item is taken. Reset empties the table
// at once through per-slot valid bits; there is no clearing pass.
module symbol_slot_registry #(
  parameter int MAX_SLOTS = 32,
  parameter int KEY_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssr_pkg::APB_AW-1:0]    paddr,
  input  logic [ssr_pkg::APB_DW-1:0]    pwdata,
  output logic [ssr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssr_pkg::FUNC_W-1:0]    in_func,
  input  logic [ssr_pkg::SLOT_W-1:0]    in_slot,
  input  logic [KEY_BITS-1:0]           in_symbol_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [ssr_pkg::ERR_W-1:0]     out_error_code,
  output logic [ssr_pkg::SLOT_W-1:0]    out_found_slot,
  output logic [KEY_BITS-1:0]           out_stored_key,
  output logic                          out_slot_enabled,
  output logic [ssr_pkg::PH_W-1:0]      out_slot_phase,
  output logic [ssr_pkg::GEN_W-1:0]     out_generation_count
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_SLOT  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // configuration
  logic [CW-1:0]                  cnt_r;
  logic [ssr_pkg::CFG_W-1:0]      cfg_val;
  logic                           cfg_we;

  // sequencer state
  logic [2:0]                     state_r, state_nxt;
  logic [ssr_pkg::FUNC_W-1:0]     func_r, func_nxt;
  logic [ssr_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [KEY_BITS-1:0]            key_r, key_nxt;
  logic [CW-1:0]                  addr_r, addr_nxt;
  logic [IW-1:0]                  cmp_idx_r, cmp_idx_nxt;
  logic                           data_ok_r, data_ok_nxt;
  logic                           find_r, find_nxt;
  logic                           ok_r, ok_nxt;
  logic [ssr_pkg::ERR_W-1:0]      err_r, err_nxt;
  logic [ssr_pkg::SLOT_W-1:0]     found_r, found_nxt;
  logic                           show_r, show_nxt;
  logic [IW-1:0]                  show_idx_r, show_idx_nxt;
  logic [KEY_BITS-1:0]            cur_key_r, cur_key_nxt;
  logic [ssr_pkg::GEN_W-1:0]      gen_r, gen_nxt;

  // slot flags
  logic                           en_r [MAX_SLOTS];
  logic [ssr_pkg::PH_W-1:0]       ph_r [MAX_SLOTS];
  logic [IW-1:0]                  sidx;
  logic [IW-1:0]                  flag_idx;
  logic                           en_rd;
  logic [ssr_pkg::PH_W-1:0]       ph_rd;
  logic                           flag_we;
  logic                           flag_en_w;
  logic [ssr_pkg::PH_W-1:0]       flag_ph_w;

  // key store
  logic                           mem_we;
  logic [KEY_BITS-1:0]            mem_wdata;
  logic [KEY_BITS-1:0]            rkey;

  // scan
  logic                           hit;
  logic                           scan_end;
  logic                           slot_oor;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r;
  logic [ssr_pkg::ERR_W-1:0]      out_err_r;
  logic [ssr_pkg::SLOT_W-1:0]     out_found_r;
  logic [KEY_BITS-1:0]            out_key_r;
  logic                           out_en_r;
  logic [ssr_pkg::PH_W-1:0]       out_ph_r;
  logic [ssr_pkg::GEN_W-1:0]      out_gen_r;
  logic                           out_load;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_val = pwdata[ssr_pkg::CFG_W-1:0];
  assign cfg_we  = psel && penable && pwrite && !paddr[2];
  assign prdata  = paddr[2] ? '0 : ssr_pkg::APB_DW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(MAX_SLOTS);
    end else if (cfg_we) begin
      if (cfg_val == '0) begin
        cnt_r <= CW'(1);
      end else if (cfg_val > ssr_pkg::CFG_W'(MAX_SLOTS)) begin
        cnt_r <= CW'(MAX_SLOTS);
      end else begin
        cnt_r <= CW'(cfg_val);
      end
    end
  end

  // ------------------------------------------------------------ key store
  ssr_key_store #(
    .DEPTH    (MAX_SLOTS),
    .KEY_BITS (KEY_BITS),
    .IW       (IW)
  ) u_key_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (sidx),
    .wdata (mem_wdata),
    .raddr (addr_r[IW-1:0]),
    .rdata (rkey)
  );

  // ---------------------------------------------------------------- flags
  assign sidx = slot_r[IW-1:0];

  always_comb begin
    unique case (state_r)
      ST_SCAN: flag_idx = cmp_idx_r;
      ST_OUT:  flag_idx = show_idx_r;
      default: flag_idx = sidx;
    endcase
  end

  assign en_rd = en_r[flag_idx];
  assign ph_rd = ph_r[flag_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        en_r[i] <= 1'b0;
        ph_r[i] <= ssr_pkg::PH_READY;
      end
    end else if (flag_we) begin
      en_r[sidx] <= flag_en_w;
      ph_r[sidx] <= flag_ph_w;
    end
  end

  // ------------------------------------------------------------ sequencer
  assign in_ready = (state_r == ST_IDLE);
  assign slot_oor = {1'b0, slot_r} >= (ssr_pkg::SLOT_W + 1)'(cnt_r);

  // dup scan skips the own slot and counts only enabled slots
  assign hit = data_ok_r && (rkey == key_r) &&
               (find_r || ((cmp_idx_r != sidx) && en_rd));
  assign scan_end = !data_ok_r && (addr_r >= cnt_r);

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    logic [ssr_pkg::ERR_W-1:0] e_v;
    logic                      go_scan;
    e_v          = ssr_pkg::ERR_NONE;
    go_scan      = 1'b0;
    state_nxt    = state_r;
    func_nxt     = func_r;
    slot_nxt     = slot_r;
    key_nxt      = key_r;
    addr_nxt     = addr_r;
    cmp_idx_nxt  = cmp_idx_r;
    data_ok_nxt  = data_ok_r;
    find_nxt     = find_r;
    ok_nxt       = ok_r;
    err_nxt      = err_r;
    found_nxt    = found_r;
    show_nxt     = show_r;
    show_idx_nxt = show_idx_r;
    cur_key_nxt  = cur_key_r;
    gen_nxt      = gen_r;
    mem_we       = 1'b0;
    mem_wdata    = key_r;
    flag_we      = 1'b0;
    flag_en_w    = 1'b0;
    flag_ph_w    = ssr_pkg::PH_READY;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_func;
          slot_nxt     = in_slot;
          key_nxt      = in_symbol_key;
          ok_nxt       = 1'b0;
          err_nxt      = ssr_pkg::ERR_NONE;
          found_nxt    = '0;
          show_nxt     = 1'b0;
          show_idx_nxt = in_slot[IW-1:0];
          state_nxt    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (func_r > ssr_pkg::FUNC_READ) begin
          state_nxt = ST_OUT;
        end else if (func_r == ssr_pkg::FUNC_FIND) begin
          if (key_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            find_nxt    = 1'b1;
            addr_nxt    = '0;
            data_ok_nxt = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end else if (slot_oor) begin
          err_nxt   = ssr_pkg::ERR_RANGE;
          state_nxt = ST_OUT;
        end else begin
          addr_nxt  = CW'(slot_r);
          show_nxt  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        cur_key_nxt = rkey;
        state_nxt   = ST_OUT;
        unique case (func_r)
          ssr_pkg::FUNC_ASSIGN: begin
            if (key_r == '0) e_v = ssr_pkg::ERR_EMPTY_KEY;
            else go_scan = 1'b1;
          end
          ssr_pkg::FUNC_CLEAR: begin
            if (ph_rd == ssr_pkg::PH_AWAIT) begin
              e_v = ssr_pkg::ERR_CLR_AWAIT;
            end else begin
              mem_we      = 1'b1;
              mem_wdata   = '0;
              flag_we     = 1'b1;
              gen_nxt     = gen_r + 1'b1;
              cur_key_nxt = '0;
            end
          end
          ssr_pkg::FUNC_ENABLE: begin
            if (rkey == '0) begin
              e_v = ssr_pkg::ERR_EN_UNASSIGNED;
            end else if (ph_rd == ssr_pkg::PH_AWAIT) begin
              e_v = ssr_pkg::ERR_EN_BEFORE_ACK;
            end else begin
              key_nxt = rkey;
              go_scan = 1'b1;
            end
          end
          ssr_pkg::FUNC_DISABLE: begin
            if (rkey == '0) begin
              e_v = ssr_pkg::ERR_DIS_UNASSIGNED;
            end else begin
              flag_we   = 1'b1;
              flag_ph_w = (ph_rd == ssr_pkg::PH_ACTIVE) ? ssr_pkg::PH_READY : ph_rd;
            end
          end
          ssr_pkg::FUNC_BEGIN: begin
            if (rkey == '0 || !en_rd || ph_rd != ssr_pkg::PH_ACTIVE) begin
              e_v = ssr_pkg::ERR_REMAP_ACTIVE;
            end else begin
              flag_we   = 1'b1;
              flag_ph_w = ssr_pkg::PH_AWAIT;
              gen_nxt   = gen_r + 1'b1;
            end
          end
          ssr_pkg::FUNC_ACK: begin
            if (ph_rd != ssr_pkg::PH_AWAIT) begin
              e_v = ssr_pkg::ERR_NO_CLEAR;
            end else begin
              mem_we      = 1'b1;
              mem_wdata   = '0;
              flag_we     = 1'b1;
              gen_nxt     = gen_r + 1'b1;
              cur_key_nxt = '0;
            end
          end
          ssr_pkg::FUNC_COMPLETE: begin
            if (ph_rd != ssr_pkg::PH_READY || rkey != '0) e_v = ssr_pkg::ERR_NOT_READY;
            else if (key_r == '0) e_v = ssr_pkg::ERR_EMPTY_KEY;
            else go_scan = 1'b1;
          end
          default: begin
          end
        endcase
        err_nxt = e_v;
        ok_nxt  = (func_r == ssr_pkg::FUNC_READ) ? (rkey != '0) : (e_v == ssr_pkg::ERR_NONE);
        if (go_scan) begin
          find_nxt    = 1'b0;
          addr_nxt    = '0;
          data_ok_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (find_r) begin
            ok_nxt       = 1'b1;
            found_nxt    = ssr_pkg::SLOT_W'(cmp_idx_r);
            show_nxt     = 1'b1;
            show_idx_nxt = cmp_idx_r;
            cur_key_nxt  = key_r;
          end else begin
            ok_nxt  = 1'b0;
            err_nxt = ssr_pkg::ERR_DUP_ACTIVE;
          end
          state_nxt = ST_OUT;
        end else if (scan_end) begin
          state_nxt = find_r ? ST_OUT : ST_APPLY;
        end else if (addr_r < cnt_r) begin
          addr_nxt    = addr_r + 1'b1;
          cmp_idx_nxt = addr_r[IW-1:0];
          data_ok_nxt = 1'b1;
        end else begin
          data_ok_nxt = 1'b0;
        end
      end
      ST_APPLY: begin
        state_nxt = ST_OUT;
        if (func_r == ssr_pkg::FUNC_ENABLE) begin
          flag_we   = 1'b1;
          flag_en_w = 1'b1;
          flag_ph_w = ssr_pkg::PH_ACTIVE;
        end else if (en_rd || ph_rd == ssr_pkg::PH_AWAIT) begin
          ok_nxt  = 1'b0;
          err_nxt = ssr_pkg::ERR_NOT_ASSIGNABLE;
        end else begin
          // assign, or complete remap which also enables
          mem_we      = 1'b1;
          flag_we     = 1'b1;
          flag_en_w   = (func_r == ssr_pkg::FUNC_COMPLETE);
          flag_ph_w   = (func_r == ssr_pkg::FUNC_COMPLETE) ? ssr_pkg::PH_ACTIVE
                                                           : ssr_pkg::PH_READY;
          gen_nxt     = gen_r + 1'b1;
          cur_key_nxt = key_r;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      data_ok_r <= 1'b0;
      find_r    <= 1'b0;
      gen_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      data_ok_r <= data_ok_nxt;
      find_r    <= find_nxt;
      gen_r     <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    slot_r     <= slot_nxt;
    key_r      <= key_nxt;
    addr_r     <= addr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    ok_r       <= ok_nxt;
    err_r      <= err_nxt;
    found_r    <= found_nxt;
    show_r     <= show_nxt;
    show_idx_r <= show_idx_nxt;
    cur_key_r  <= cur_key_nxt;
  end

  // ------------------------------------------------------- result register
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // flags are read after the step has written them
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= ok_r;
      out_err_r   <= err_r;
      out_found_r <= found_r;
      out_key_r   <= show_r ? cur_key_r : '0;
      out_en_r    <= show_r ? en_rd : 1'b0;
      out_ph_r    <= show_r ? ph_rd : ssr_pkg::PH_READY;
      out_gen_r   <= gen_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ok               = out_ok_r;
  assign out_error_code       = out_err_r;
  assign out_found_slot       = out_found_r;
  assign out_stored_key       = out_key_r;
  assign out_slot_enabled     = out_en_r;
  assign out_slot_phase       = out_ph_r;
  assign out_generation_count = out_gen_r;

endmodule

// ===== src/ssr_key_store.sv =====
// ----------------------------------------------------------------------------
// ssr_key_store
// Slot key memory: one write port, one registered read port, and a valid
// bit per entry so that reset empties the table at once.
// ----------------------------------------------------------------------------
module ssr_key_store #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 64,
  parameter int IW       = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  logic [KEY_BITS-1:0] wdata,
  input  logic [IW-1:0]       raddr,
  output logic [KEY_BITS-1:0] rdata
);

  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_key_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  // an entry never written reads as no symbol
  assign rdata = rd_vld_r ? rd_key_r : '0;

endmodule

// ===== src/ssr_checker.sv =====
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks on the result channel of the symbol slot registry.
// ----------------------------------------------------------------------------
module ssr_checker #(
  parameter int KEY_BITS = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [ssr_pkg::ERR_W-1:0]     out_error_code,
  input logic [KEY_BITS-1:0]           out_stored_key,
  input logic                          out_slot_enabled,
  input logic [ssr_pkg::PH_W-1:0]      out_slot_phase
);

  // a waiting result item is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // success never carries an error code
  a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_error_code == ssr_pkg::ERR_NONE)
    else $error("ok result with an error code");

  // an out-of-range slot shows no slot contents
  a_range_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ssr_pkg::ERR_RANGE |->
      out_stored_key == '0 && !out_slot_enabled &&
      out_slot_phase == ssr_pkg::PH_READY)
    else $error("out-of-range result shows slot contents");

  // a slot awaiting clear acknowledgement is never enabled
  a_await_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot_phase == ssr_pkg::PH_AWAIT |-> !out_slot_enabled)
    else $error("slot enabled while awaiting clear ack");

endmodule

bind symbol_slot_registry ssr_checker #(.KEY_BITS(KEY_BITS)) u_ssr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_ok           (out_ok),
  .out_error_code   (out_error_code),
  .out_stored_key   (out_stored_key),
  .out_slot_enabled (out_slot_enabled),
  .out_slot_phase   (out_slot_phase)
);

// ===== tb/sv/tb_symbol_slot_registry.sv =====
// ----------------------------------------------------------------------------
// tb_symbol_slot_registry
// Self-checking bench for the symbol slot registry. A scoreboard keeps its
// own copy of the slot table and predicts each reply. A short directed run
// covers every guard. Random request streams then run under several
// slot_count settings, with random gaps on both channels, a gap-free
// stretch and one long output back-pressure window.
// ----------------------------------------------------------------------------
module tb_symbol_slot_registry;

  localparam int MAX_SLOTS = 32;
  localparam int KEY_W     = 64;
  localparam int POOL_N    = 12;
  localparam int PHASES    = 7;
  localparam int PER_PHASE = 57;
  localparam int DRAIN_CYC = 48;
  localparam logic [ssr_pkg::APB_AW-1:0] ADDR_SLOT_COUNT = '0;

  typedef struct {
    logic                       ok;
    logic [ssr_pkg::ERR_W-1:0]  err;
    logic [ssr_pkg::SLOT_W-1:0] found;
    logic [KEY_W-1:0]           key;
    logic                       en;
    logic [ssr_pkg::PH_W-1:0]   phase;
    logic [ssr_pkg::GEN_W-1:0]  gen;
  } reply_t;

  class slot_table_scoreboard;
    logic [KEY_W-1:0]          keys [MAX_SLOTS];
    logic                      enabled [MAX_SLOTS];
    logic [ssr_pkg::PH_W-1:0]  phase [MAX_SLOTS];
    logic [ssr_pkg::GEN_W-1:0] gen;
    int unsigned               slots_in_use;
    reply_t                    due [$];
    int                        errors;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        keys[i]    = '0;
        enabled[i] = 1'b0;
        phase[i]   = ssr_pkg::PH_READY;
      end
      gen          = '0;
      slots_in_use = MAX_SLOTS;
      errors       = 0;
    endfunction

    function void set_slot_count(logic [ssr_pkg::APB_DW-1:0] v);
      int unsigned c;
      c = v[ssr_pkg::CFG_W-1:0];
      if (c < 1) c = 1;
      if (c > MAX_SLOTS) c = MAX_SLOTS;
      slots_in_use = c;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function bit dup_enabled(int unsigned s, logic [KEY_W-1:0] k);
      for (int unsigned i = 0; i < slots_in_use; i++)
        if (i != s && enabled[i] && keys[i] == k) return 1'b1;
      return 1'b0;
    endfunction

    function void release_slot(int unsigned s);
      keys[s]    = '0;
      enabled[s] = 1'b0;
      phase[s]   = ssr_pkg::PH_READY;
      gen++;
    endfunction

    function logic [ssr_pkg::ERR_W-1:0] try_assign(int unsigned s, logic [KEY_W-1:0] k);
      if (k == '0) return ssr_pkg::ERR_EMPTY_KEY;
      if (dup_enabled(s, k)) return ssr_pkg::ERR_DUP_ACTIVE;
      if (enabled[s] || phase[s] == ssr_pkg::PH_AWAIT) return ssr_pkg::ERR_NOT_ASSIGNABLE;
      keys[s]    = k;
      enabled[s] = 1'b0;
      phase[s]   = ssr_pkg::PH_READY;
      gen++;
      return ssr_pkg::ERR_NONE;
    endfunction

    function logic [ssr_pkg::ERR_W-1:0] try_enable(int unsigned s);
      if (keys[s] == '0) return ssr_pkg::ERR_EN_UNASSIGNED;
      if (phase[s] == ssr_pkg::PH_AWAIT) return ssr_pkg::ERR_EN_BEFORE_ACK;
      if (dup_enabled(s, keys[s])) return ssr_pkg::ERR_DUP_ACTIVE;
      enabled[s] = 1'b1;
      phase[s]   = ssr_pkg::PH_ACTIVE;
      return ssr_pkg::ERR_NONE;
    endfunction

    function void note_request(logic [ssr_pkg::FUNC_W-1:0] f,
                               logic [ssr_pkg::SLOT_W-1:0] s,
                               logic [KEY_W-1:0] k);
      reply_t      r;
      bit          show;
      int unsigned at;
      r.ok    = 1'b0;
      r.err   = ssr_pkg::ERR_NONE;
      r.found = '0;
      r.key   = '0;
      r.en    = 1'b0;
      r.phase = ssr_pkg::PH_READY;
      show    = 1'b0;
      at      = s;
      if (f <= ssr_pkg::FUNC_READ && f != ssr_pkg::FUNC_FIND) begin
        if (s >= slots_in_use) begin
          r.err = ssr_pkg::ERR_RANGE;
        end else begin
          show = 1'b1;
          unique case (f)
            ssr_pkg::FUNC_ASSIGN: r.err = try_assign(s, k);
            ssr_pkg::FUNC_CLEAR: begin
              if (phase[s] == ssr_pkg::PH_AWAIT) r.err = ssr_pkg::ERR_CLR_AWAIT;
              else release_slot(s);
            end
            ssr_pkg::FUNC_ENABLE: r.err = try_enable(s);
            ssr_pkg::FUNC_DISABLE: begin
              if (keys[s] == '0) begin
                r.err = ssr_pkg::ERR_DIS_UNASSIGNED;
              end else begin
                enabled[s] = 1'b0;
                if (phase[s] == ssr_pkg::PH_ACTIVE) phase[s] = ssr_pkg::PH_READY;
              end
            end
            ssr_pkg::FUNC_BEGIN: begin
              if (keys[s] == '0 || !enabled[s] || phase[s] != ssr_pkg::PH_ACTIVE) begin
                r.err = ssr_pkg::ERR_REMAP_ACTIVE;
              end else begin
                enabled[s] = 1'b0;
                phase[s]   = ssr_pkg::PH_AWAIT;
                gen++;
              end
            end
            ssr_pkg::FUNC_ACK: begin
              if (phase[s] != ssr_pkg::PH_AWAIT) r.err = ssr_pkg::ERR_NO_CLEAR;
              else release_slot(s);
            end
            ssr_pkg::FUNC_COMPLETE: begin
              // only a ready, empty slot; assign then enable in one go
              if (phase[s] != ssr_pkg::PH_READY || keys[s] != '0) begin
                r.err = ssr_pkg::ERR_NOT_READY;
              end else begin
                r.err = try_assign(s, k);
                if (r.err == ssr_pkg::ERR_NONE) r.err = try_enable(s);
              end
            end
            default: ;
          endcase
          r.ok = (f == ssr_pkg::FUNC_READ) ? (keys[s] != '0)
                                           : (r.err == ssr_pkg::ERR_NONE);
        end
      end else if (f == ssr_pkg::FUNC_FIND && k != '0) begin
        for (int unsigned i = 0; i < slots_in_use && !show; i++) begin
          if (keys[i] == k) begin
            r.ok    = 1'b1;
            r.found = ssr_pkg::SLOT_W'(i);
            show    = 1'b1;
            at      = i;
          end
        end
      end
      if (show) begin
        r.key   = keys[at];
        r.en    = enabled[at];
        r.phase = phase[at];
      end
      r.gen = gen;
      due.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(reply_t got);
      reply_t want;
      string  diff;
      if (due.size() == 0) begin
        report($sformatf("reply with no request pending: ok=%0d err=%0d gen=%0d",
                         got.ok, got.err, got.gen));
        return;
      end
      want = due.pop_front();
      diff = "";
      if (got.ok !== want.ok) diff = {diff, " ok"};
      if (got.err !== want.err) diff = {diff, " error_code"};
      if (got.found !== want.found) diff = {diff, " found_slot"};
      if (got.key !== want.key) diff = {diff, " stored_key"};
      if (got.en !== want.en) diff = {diff, " slot_enabled"};
      if (got.phase !== want.phase) diff = {diff, " slot_phase"};
      if (got.gen !== want.gen) diff = {diff, " generation_count"};
      if (diff != "") begin
        diff = {diff, $sformatf(
          " | got ok=%0d err=%0d slot=%0d key=%h en=%0d ph=%0d gen=%0d",
          got.ok, got.err, got.found, got.key, got.en, got.phase, got.gen)};
        diff = {diff, $sformatf(
          " | want ok=%0d err=%0d slot=%0d key=%h en=%0d ph=%0d gen=%0d",
          want.ok, want.err, want.found, want.key, want.en, want.phase, want.gen)};
        report(diff);
      end
    endtask
  endclass

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [ssr_pkg::APB_AW-1:0]    paddr         = '0;
  logic [ssr_pkg::APB_DW-1:0]    pwdata        = '0;
  logic [ssr_pkg::APB_DW-1:0]    prdata;
  logic                          pready;
  logic                          in_valid      = 1'b0;
  logic                          in_ready;
  logic [ssr_pkg::FUNC_W-1:0]    in_func       = '0;
  logic [ssr_pkg::SLOT_W-1:0]    in_slot       = '0;
  logic [KEY_W-1:0]              in_symbol_key = '0;
  logic                          out_valid;
  logic                          out_ready     = 1'b0;
  logic                          out_ok;
  logic [ssr_pkg::ERR_W-1:0]     out_error_code;
  logic [ssr_pkg::SLOT_W-1:0]    out_found_slot;
  logic [KEY_W-1:0]              out_stored_key;
  logic                          out_slot_enabled;
  logic [ssr_pkg::PH_W-1:0]      out_slot_phase;
  logic [ssr_pkg::GEN_W-1:0]     out_generation_count;

  slot_table_scoreboard regs = new();
  logic [KEY_W-1:0]     key_pool [POOL_N];
  bit                   calm = 1'b0;
  int                   replies_seen = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  reply_t               seen_reply;

  symbol_slot_registry #(
    .MAX_SLOTS(MAX_SLOTS),
    .KEY_BITS (KEY_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_slot             (in_slot),
    .in_symbol_key       (in_symbol_key),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ok              (out_ok),
    .out_error_code      (out_error_code),
    .out_found_slot      (out_found_slot),
    .out_stored_key      (out_stored_key),
    .out_slot_enabled    (out_slot_enabled),
    .out_slot_phase      (out_slot_phase),
    .out_generation_count(out_generation_count)
  );

  always #6 clk = ~clk;

  initial begin
    #4800000;
    $display("status: fail");
    $finish;
  end

  // reply side: random back-pressure plus one long hold that fills the block
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen_reply.ok    = out_ok;
      seen_reply.err   = out_error_code;
      seen_reply.found = out_found_slot;
      seen_reply.key   = out_stored_key;
      seen_reply.en    = out_slot_enabled;
      seen_reply.phase = out_slot_phase;
      seen_reply.gen   = out_generation_count;
      regs.check_result(seen_reply);
      replies_seen++;
    end
    if (!hold_done && replies_seen >= 120) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(POOL_N-1)];
  endfunction

  task automatic send_request(input logic [ssr_pkg::FUNC_W-1:0] f,
                              input logic [ssr_pkg::SLOT_W-1:0] s,
                              input logic [KEY_W-1:0] k);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 32) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_slot       <= s;
    in_symbol_key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    regs.note_request(f, s, k);
  endtask

  task automatic write_slot_count(input logic [ssr_pkg::APB_DW-1:0] v);
    in_valid <= 1'b0;
    while (regs.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SLOT_COUNT;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    regs.set_slot_count(v);
  endtask

  // mostly requests that fit the slot's current phase, the rest noise
  task automatic pick_request(output logic [ssr_pkg::FUNC_W-1:0] f,
                              output logic [ssr_pkg::SLOT_W-1:0] s,
                              output logic [KEY_W-1:0] k);
    int unsigned r;
    if ($urandom_range(9) == 0) s = ssr_pkg::SLOT_W'($urandom_range(MAX_SLOTS-1));
    else s = ssr_pkg::SLOT_W'($urandom_range(regs.slots_in_use - 1));
    k = pool_key();
    r = $urandom_range(99);
    if (r < 30) begin
      if ($urandom_range(9) == 0)
        f = ssr_pkg::FUNC_W'($urandom_range(15, ssr_pkg::FUNC_READ + 1));
      else
        f = ssr_pkg::FUNC_W'($urandom_range(ssr_pkg::FUNC_READ));
      s = ssr_pkg::SLOT_W'($urandom_range(MAX_SLOTS-1));
      r = $urandom_range(9);
      if (r == 0) k = '0;
      else if (r < 4) k = {$urandom, $urandom};
      return;
    end
    r = $urandom_range(99);
    if (regs.phase[s] == ssr_pkg::PH_AWAIT) begin
      f = (r < 70) ? ssr_pkg::FUNC_ACK : (r < 80) ? ssr_pkg::FUNC_CLEAR :
          (r < 90) ? ssr_pkg::FUNC_ENABLE : ssr_pkg::FUNC_ASSIGN;
    end else if (regs.keys[s] == '0) begin
      f = (r < 50) ? ssr_pkg::FUNC_ASSIGN : (r < 90) ? ssr_pkg::FUNC_COMPLETE :
          ssr_pkg::FUNC_READ;
    end else if (!regs.enabled[s]) begin
      f = (r < 55) ? ssr_pkg::FUNC_ENABLE : (r < 70) ? ssr_pkg::FUNC_CLEAR :
          (r < 85) ? ssr_pkg::FUNC_DISABLE : ssr_pkg::FUNC_READ;
    end else begin
      f = (r < 45) ? ssr_pkg::FUNC_BEGIN : (r < 70) ? ssr_pkg::FUNC_FIND :
          (r < 85) ? ssr_pkg::FUNC_DISABLE : ssr_pkg::FUNC_READ;
      if (f == ssr_pkg::FUNC_FIND) k = regs.keys[s];
    end
  endtask

  initial begin
    logic [ssr_pkg::FUNC_W-1:0] f;
    logic [ssr_pkg::SLOT_W-1:0] s;
    logic [KEY_W-1:0]           k;
    logic [ssr_pkg::APB_DW-1:0] cfg;
    logic [KEY_W-1:0]           k2;

    k2 = 64'h8000_0000_0000_0001;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // guards and phase rules, full table
    send_request(ssr_pkg::FUNC_READ,     5'd0,  '0);
    send_request(ssr_pkg::FUNC_FIND,     5'd0,  '0);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd0,  '0);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd0,  '1);
    send_request(ssr_pkg::FUNC_ENABLE,   5'd1,  '0);
    send_request(ssr_pkg::FUNC_DISABLE,  5'd1,  '0);
    send_request(ssr_pkg::FUNC_ENABLE,   5'd0,  '0);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd31, '1);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd0,  64'h1234);
    send_request(ssr_pkg::FUNC_FIND,     5'd0,  '1);
    send_request(ssr_pkg::FUNC_BEGIN,    5'd31, '0);
    send_request(ssr_pkg::FUNC_BEGIN,    5'd0,  '0);
    send_request(ssr_pkg::FUNC_CLEAR,    5'd0,  '0);
    send_request(ssr_pkg::FUNC_ENABLE,   5'd0,  '0);
    send_request(ssr_pkg::FUNC_COMPLETE, 5'd0,  64'h1);
    send_request(ssr_pkg::FUNC_ACK,      5'd31, '0);
    send_request(ssr_pkg::FUNC_ACK,      5'd0,  '0);
    send_request(ssr_pkg::FUNC_COMPLETE, 5'd31, 64'h1);
    send_request(ssr_pkg::FUNC_DISABLE,  5'd31, '0);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd20, k2);
    send_request(4'd15,                  5'd31, '1);

    // zero write clamps to one slot; slot 20 falls outside the scan
    write_slot_count('0);
    send_request(ssr_pkg::FUNC_READ,     5'd1,  '0);
    send_request(ssr_pkg::FUNC_FIND,     5'd0,  k2);
    send_request(ssr_pkg::FUNC_ASSIGN,   5'd0,  k2);
    send_request(ssr_pkg::FUNC_READ,     5'd0,  '0);

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: cfg = 32'd32;
        1: cfg = 32'd1;
        2: cfg = 32'd63;
        3: cfg = 32'd2;
        4: cfg = {26'($urandom_range(32'h03FF_FFFF, 1)), 6'd5};
        5: cfg = 32'd17;
        default: cfg = 32'd31;
      endcase
      write_slot_count(cfg);
      key_pool[0] = '1;
      key_pool[1] = 64'h1;
      for (int i = 2; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
      calm = (p == 2);
      for (int n = 0; n < PER_PHASE; n++) begin
        pick_request(f, s, k);
        send_request(f, s, k);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (regs.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (regs.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ssr_pkg.sv
src/ssr_key_store.sv
src/symbol_slot_registry.sv
src/ssr_checker.sv
tb/sv/tb_symbol_slot_registry.sv
